@@ sv/rsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rsc_pkg - ray sample compositor shared definitions
// Mode and register codes, fixed-point constants and rounding helper.
// ----------------------------------------------------------------------------
package rsc_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int PIXEL_W  = 8;
    localparam int MODE_W   = 3;
    localparam int TH_W     = 16;
    localparam int SCALE_W  = 23;
    localparam int STEPS_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    // state widths
    localparam int ACC_W = 24;
    localparam int COV_W = 17;
    localparam int SUM_W = 28;

    // shared multiplier operand width
    localparam int MUL_W = 24;

    // compositing modes
    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAX   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MEAN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ALPHA = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMP_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SCALE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_RAY   = 2'd3;

    // fixed-point constants
    localparam logic [TH_W-1:0]     TH_MAX     = 16'd64881;    // 0.99 in Q0.16
    localparam logic [COV_W-1:0]    ONE_Q16    = 17'd65536;
    localparam logic [COV_W-1:0]    DONE_COV   = 17'd64226;    // 0.98 in Q0.16
    localparam logic [ACC_W-1:0]    ACC_MAX    = 24'hFF_FFFF;
    localparam logic [SUM_W-1:0]    SUM_MAX    = 28'hFFF_FFFF;
    localparam logic [SAMPLE_W-1:0] MIN_RESET  = 16'hFF00;     // 255.0 in Q8.8
    // ceil(2^31 / 255): exact floor division by 255 for values below 2^24
    localparam logic [MUL_W-1:0]    RECIP_255  = 24'h80_8081;
    // scaled product at or above this clamps opacity to one
    localparam logic [30:0]         ALPHA_SAT  = 31'd16711935;
    localparam logic [PIXEL_W-1:0]  PIXEL_MAX  = 8'd255;

    // round a Q8.8 value half up and saturate to a pixel
    function automatic logic [PIXEL_W-1:0] round_q88(input logic [SAMPLE_W-1:0] x);
        logic [SAMPLE_W:0] r;
        begin
            r = {1'b0, x} + 17'd128;
            round_q88 = r[SAMPLE_W] ? PIXEL_MAX : r[SAMPLE_W-1:8];
        end
    endfunction

endpackage

@@ sv/ray_sample_compositor.sv @@
// ----------------------------------------------------------------------------
// ray_sample_compositor - per-ray sample reduction to one pixel
// Pass-through, minimum, maximum, mean and front-to-back alpha compositing
// of Q8.8 volume samples, one 8-bit pixel per ray or per pass-through sample.
// ----------------------------------------------------------------------------
// Samples of one ray arrive in front-to-back order on the sample channel
// (sample_valid / sample_stall); the last sample carries ray_last, and a
// ray_void request gives pixel 0 and clears the ray. Pixels leave on
// the pixel channel through an output register, so a pixel may wait for the
// consumer while the next sample is taken in. The block works on one request
// at a time and stalls the sample channel until it is done. A sample that
// yields no pixel in minimum, maximum and mean mode needs only the idle
// state; a pixel-producing request (pass-through, minimum, maximum, void,
// unused modes) also passes the pixel-write state. An alpha sample that
// adds opacity makes five passes through the single shared 24x24
// multiplier (two partial products of the opacity gain, the divide by 255
// as a reciprocal multiply, the coverage weight and the color weight);
// alpha samples below the threshold or after early stop skip them. The
// mean pixel at ray end comes from an eight-step restoring divide by
// steps_per_ray, skipped when steps_per_ray is 0 or the result saturates.
// Configuration is written on cfg_valid / cfg_ready, always ready; the
// user must write it only while no request is in flight; not enforced.
// ----------------------------------------------------------------------------
module ray_sample_compositor (
    input  logic                            clk,
    input  logic                            rst_n,

    // sample channel
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [rsc_pkg::SAMPLE_W-1:0]    sample_value,
    input  logic                            ray_last,
    input  logic                            ray_void,

    // pixel channel
    output logic                            pixel_valid,
    input  logic                            pixel_stall,
    output logic [rsc_pkg::PIXEL_W-1:0]     pixel,

    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;   // take a request
    localparam logic [3:0] ST_M0   = 4'd1;   // d * gain low half
    localparam logic [3:0] ST_M1   = 4'd2;   // d * gain high half
    localparam logic [3:0] ST_M2   = 4'd3;   // combine halves, clamp check
    localparam logic [3:0] ST_M3   = 4'd4;   // divide by 255 via reciprocal
    localparam logic [3:0] ST_M4   = 4'd5;   // coverage weight
    localparam logic [3:0] ST_M5   = 4'd6;   // color weight, state update
    localparam logic [3:0] ST_DSET = 4'd7;   // mean divide setup
    localparam logic [3:0] ST_DIV  = 4'd8;   // one quotient bit per cycle
    localparam logic [3:0] ST_FIN  = 4'd9;   // write pixel, clear ray on last or void

    // configuration
    logic [rsc_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [rsc_pkg::TH_W-1:0]     th_reg, th_next;
    logic [rsc_pkg::SCALE_W-1:0]  scale_reg, scale_next;
    logic [rsc_pkg::STEPS_W-1:0]  steps_reg, steps_next;

    // ray state
    logic [rsc_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [rsc_pkg::COV_W-1:0]    cov_reg, cov_next;
    logic [rsc_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic [rsc_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic [rsc_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic                         done_reg, done_next;

    // control
    logic [3:0]                   state_reg, state_next;
    logic                         out_valid_reg, out_valid_next;

    // datapath registers (no reset)
    logic [rsc_pkg::PIXEL_W-1:0]  pixel_reg, pixel_next;
    logic [rsc_pkg::SAMPLE_W-1:0] v_reg, v_next;
    logic                         last_reg, last_next;
    logic                         void_reg, void_next;
    logic [23:0]                  d_reg, d_next;
    logic [35:0]                  plo_reg, plo_next;
    logic [34:0]                  phi_reg, phi_next;
    logic [23:0]                  y_reg, y_next;
    logic                         ysat_reg, ysat_next;
    logic [16:0]                  a_reg, a_next;
    logic [16:0]                  w_reg, w_next;
    logic [20:0]                  rem_reg, rem_next;
    logic [7:0]                   q_reg, q_next;
    logic [2:0]                   bit_reg, bit_next;

    // shared multiplier
    logic [rsc_pkg::MUL_W-1:0]    mul_a;
    logic [rsc_pkg::MUL_W-1:0]    mul_b;
    logic [2*rsc_pkg::MUL_W-1:0]  product;

    // combinational helpers
    logic [23:0]                  vn;
    logic [23:0]                  tn;
    logic [46:0]                  scaled;
    logic [28:0]                  mean_num;
    logic [20:0]                  mean_div;
    logic [20:0]                  trial;
    logic [24:0]                  acc_sum;
    logic [24:0]                  acc_round;
    logic [rsc_pkg::COV_W-1:0]    cov_inc;
    logic [rsc_pkg::PIXEL_W-1:0]  fin_pixel;
    logic                         out_free;
    logic                         accept;

    assign sample_stall = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign pixel_valid  = out_valid_reg;
    assign pixel        = pixel_reg;

    assign accept   = sample_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !pixel_stall;

    // sample and threshold on a common Q8.16-by-255 scale
    assign vn = {sample_value, 8'h00};
    assign tn = {th_reg, 8'h00} - {8'h00, th_reg};

    assign scaled    = {11'd0, plo_reg} + {phi_reg, 12'd0};
    // (2*sum + 256n) / (512n) reduces to floor((sum + 128n) / 256) / n
    assign mean_num  = {1'b0, sum_reg} + {9'd0, steps_reg, 7'd0};
    assign mean_div  = {steps_reg, 8'd0};
    assign trial     = {8'd0, steps_reg} << bit_reg;
    assign cov_inc   = cov_reg + w_reg;
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, product[31:8]};
    assign acc_round = {1'b0, acc_reg} + 25'd32768;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = d_reg;
        mul_b = {12'd0, scale_reg[11:0]};
        unique case (state_reg)
            ST_M1:
            begin
                mul_a = d_reg;
                mul_b = {13'd0, scale_reg[22:12]};
            end
            ST_M3:
            begin
                mul_a = y_reg;
                mul_b = rsc_pkg::RECIP_255;
            end
            ST_M4:
            begin
                mul_a = {7'd0, rsc_pkg::ONE_Q16 - cov_reg};
                mul_b = {7'd0, a_reg};
            end
            ST_M5:
            begin
                mul_a = {7'd0, w_reg};
                mul_b = {8'd0, v_reg};
            end
            default:
            begin
                mul_a = d_reg;
                mul_b = {12'd0, scale_reg[11:0]};
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // pixel at ray end or for a pass-through sample
    always_comb
    begin
        fin_pixel = '0;
        if (!void_reg)
        begin
            case (mode_reg)
                rsc_pkg::MODE_NONE: fin_pixel = rsc_pkg::round_q88(v_reg);
                rsc_pkg::MODE_MIN:  fin_pixel = rsc_pkg::round_q88(min_reg);
                rsc_pkg::MODE_MAX:  fin_pixel = rsc_pkg::round_q88(max_reg);
                rsc_pkg::MODE_MEAN: fin_pixel = q_reg;
                rsc_pkg::MODE_ALPHA:
                begin
                    fin_pixel = acc_round[24] ? rsc_pkg::PIXEL_MAX : acc_round[23:16];
                end
                default:            fin_pixel = '0;
            endcase
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        th_next        = th_reg;
        scale_next     = scale_reg;
        steps_next     = steps_reg;
        acc_next       = acc_reg;
        cov_next       = cov_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        done_next      = done_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        pixel_next     = pixel_reg;
        v_next         = v_reg;
        last_next      = last_reg;
        void_next      = void_reg;
        d_next         = d_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        y_next         = y_reg;
        ysat_next      = ysat_reg;
        a_next         = a_reg;
        w_next         = w_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rsc_pkg::REG_COMP_MODE:
                    mode_next = cfg_data[rsc_pkg::MODE_W-1:0];
                rsc_pkg::REG_ALPHA_THRESHOLD:
                    th_next = (cfg_data[15:0] > rsc_pkg::TH_MAX) ? rsc_pkg::TH_MAX
                                                                 : cfg_data[15:0];
                rsc_pkg::REG_ALPHA_SCALE:
                    scale_next = cfg_data;
                rsc_pkg::REG_STEPS_PER_RAY:
                    steps_next = cfg_data[rsc_pkg::STEPS_W-1:0];
                default: ;
            endcase
        end

        // pixel taken by the consumer
        if (out_valid_reg && !pixel_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    v_next    = sample_value;
                    last_next = ray_last;
                    void_next = ray_void;
                    if (ray_void)
                        state_next = ST_FIN;
                    else
                    begin
                        case (mode_reg)
                            rsc_pkg::MODE_NONE:
                                state_next = ST_FIN;
                            rsc_pkg::MODE_MIN:
                            begin
                                if (sample_value < min_reg)
                                    min_next = sample_value;
                                state_next = ray_last ? ST_FIN : ST_IDLE;
                            end
                            rsc_pkg::MODE_MAX:
                            begin
                                if (sample_value > max_reg)
                                    max_next = sample_value;
                                state_next = ray_last ? ST_FIN : ST_IDLE;
                            end
                            rsc_pkg::MODE_MEAN:
                            begin
                                if (({1'b0, sum_reg} + {13'd0, sample_value})
                                    > {1'b0, rsc_pkg::SUM_MAX})
                                    sum_next = rsc_pkg::SUM_MAX;
                                else
                                    sum_next = sum_reg + {12'd0, sample_value};
                                state_next = ray_last ? ST_DSET : ST_IDLE;
                            end
                            rsc_pkg::MODE_ALPHA:
                            begin
                                // early stop or below threshold adds nothing
                                if (!done_reg && (vn > tn))
                                begin
                                    d_next     = vn - tn;
                                    state_next = ST_M0;
                                end
                                else
                                    state_next = ray_last ? ST_FIN : ST_IDLE;
                            end
                            default:
                                state_next = ray_last ? ST_FIN : ST_IDLE;
                        endcase
                    end
                end
            end
            ST_M0:
            begin
                plo_next   = product[35:0];
                state_next = ST_M1;
            end
            ST_M1:
            begin
                phi_next   = product[34:0];
                state_next = ST_M2;
            end
            ST_M2:
            begin
                // floor(d*gain / 2^16), then clamp check before the /255
                ysat_next  = (scaled[46:16] >= rsc_pkg::ALPHA_SAT);
                y_next     = scaled[39:16];
                state_next = ST_M3;
            end
            ST_M3:
            begin
                a_next     = ysat_reg ? rsc_pkg::ONE_Q16 : product[47:31];
                state_next = ST_M4;
            end
            ST_M4:
            begin
                w_next     = product[32:16];
                state_next = ST_M5;
            end
            ST_M5:
            begin
                cov_next   = cov_inc;
                acc_next   = acc_sum[24] ? rsc_pkg::ACC_MAX : acc_sum[23:0];
                if (cov_inc >= rsc_pkg::DONE_COV)
                    done_next = 1'b1;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_DSET:
            begin
                q_next   = '0;
                rem_next = mean_num[28:8];
                bit_next = 3'd7;
                if (steps_reg == '0)
                    state_next = ST_FIN;
                else if (mean_num[28:8] >= mean_div)
                begin
                    q_next     = rsc_pkg::PIXEL_MAX;
                    state_next = ST_FIN;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next         = rem_reg - trial;
                    q_next[bit_reg]  = 1'b1;
                end
                if (bit_reg == 3'd0)
                    state_next = ST_FIN;
                else
                    bit_next = bit_reg - 3'd1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pixel_next     = fin_pixel;
                    if (void_reg || last_reg)
                    begin
                        acc_next  = '0;
                        cov_next  = '0;
                        min_next  = rsc_pkg::MIN_RESET;
                        max_next  = '0;
                        sum_next  = '0;
                        done_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= rsc_pkg::MODE_NONE;
            th_reg        <= '0;
            scale_reg     <= 23'd65536;
            steps_reg     <= 13'd1;
            acc_reg       <= '0;
            cov_reg       <= '0;
            min_reg       <= rsc_pkg::MIN_RESET;
            max_reg       <= '0;
            sum_reg       <= '0;
            done_reg      <= 1'b0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            th_reg        <= th_next;
            scale_reg     <= scale_next;
            steps_reg     <= steps_next;
            acc_reg       <= acc_next;
            cov_reg       <= cov_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            done_reg      <= done_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
        v_reg     <= v_next;
        last_reg  <= last_next;
        void_reg  <= void_next;
        d_reg     <= d_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        y_reg     <= y_next;
        ysat_reg  <= ysat_next;
        a_reg     <= a_next;
        w_reg     <= w_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        bit_reg   <= bit_next;
    end

endmodule

@@ tb/sv/ray_sample_compositor_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_sample_compositor_test - self-checking bench for the ray compositor
// Drives rays of Q8.8 samples under every compositing mode and varied register
// settings, predicts each pixel in the bench and compares it on arrival.
// ----------------------------------------------------------------------------
module ray_sample_compositor_test;

    // clock and reset, all block inputs known from time zero
    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             sample_valid = 1'b0;
    logic                             sample_stall;
    logic [rsc_pkg::SAMPLE_W-1:0]     sample_value = '0;
    logic                             ray_last     = 1'b0;
    logic                             ray_void     = 1'b0;
    logic                             pixel_valid;
    logic                             pixel_stall  = 1'b0;
    logic [rsc_pkg::PIXEL_W-1:0]      pixel;
    logic                             cfg_valid    = 1'b0;
    logic                             cfg_ready;
    logic [rsc_pkg::CFG_IDX_W-1:0]    cfg_index    = '0;
    logic [rsc_pkg::CFG_DATA_W-1:0]   cfg_data     = '0;

    // register copies held by the bench
    logic [rsc_pkg::MODE_W-1:0]       cur_mode;
    logic [rsc_pkg::TH_W-1:0]         cur_th;
    logic [rsc_pkg::SCALE_W-1:0]      cur_scale;
    logic [rsc_pkg::STEPS_W-1:0]      cur_steps;

    // ray state held by the bench
    logic [rsc_pkg::ACC_W-1:0]        color_acc;
    logic [rsc_pkg::COV_W-1:0]        cov;
    logic [rsc_pkg::SAMPLE_W-1:0]     run_min;
    logic [rsc_pkg::SAMPLE_W-1:0]     run_max;
    logic [rsc_pkg::SUM_W-1:0]        run_sum;
    bit                               early_stop;

    // pixels predicted but not yet seen on the pixel channel
    logic [rsc_pkg::PIXEL_W-1:0]      pending_pixels[$];

    // largest idle gap per request on each side, 0 gives back-to-back traffic
    int                               max_src_gap  = 0;
    int                               max_sink_gap = 0;
    int                               sink_hold    = 0;

    int                               fail_count     = 0;
    int                               samples_sent   = 0;
    int                               pixels_checked = 0;
    int                               reg_writes     = 0;

    ray_sample_compositor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .ray_last     (ray_last),
        .ray_void     (ray_void),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // pixel prediction
    // ------------------------------------------------------------------------

    // start a fresh ray: min starts at 255.0, everything else at zero
    function automatic void clear_ray();
        color_acc  = '0;
        cov        = '0;
        run_min    = rsc_pkg::MIN_RESET;
        run_max    = '0;
        run_sum    = '0;
        early_stop = 1'b0;
    endfunction

    // Q8.8 rounded half up, saturated at 255
    function automatic logic [rsc_pkg::PIXEL_W-1:0] q88_to_pixel(
        input logic [rsc_pkg::SAMPLE_W-1:0] x);
        int r;
        r = (int'(x) + 128) >> 8;
        return (r > 255) ? 8'd255 : 8'(r);
    endfunction

    // mirror a register write into the bench copies
    function automatic void apply_reg(input logic [rsc_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [rsc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rsc_pkg::REG_COMP_MODE:       cur_mode = data[rsc_pkg::MODE_W-1:0];
            // thresholds above 0.99 act as 0.99
            rsc_pkg::REG_ALPHA_THRESHOLD:
                cur_th = (data[rsc_pkg::TH_W-1:0] > rsc_pkg::TH_MAX)
                         ? rsc_pkg::TH_MAX : data[rsc_pkg::TH_W-1:0];
            rsc_pkg::REG_ALPHA_SCALE:     cur_scale = data[rsc_pkg::SCALE_W-1:0];
            rsc_pkg::REG_STEPS_PER_RAY:   cur_steps = data[rsc_pkg::STEPS_W-1:0];
            default: ;
        endcase
    endfunction

    // one accepted sample request in, the pixel it yields out (-1 for none)
    function automatic int predict_pixel(input logic [rsc_pkg::SAMPLE_W-1:0] v,
                                         input bit last, input bit vd);
        longint unsigned vn, tn, a, w, acc, n, q, s;
        int r;
        // a void ray ignores value and last mark in every mode
        if (vd)
        begin
            clear_ray();
            return 0;
        end
        case (cur_mode)
            rsc_pkg::MODE_NONE:
            begin
                r = q88_to_pixel(v);
                if (last)
                    clear_ray();
                return r;
            end
            rsc_pkg::MODE_MIN:
                if (v < run_min)
                    run_min = v;
            rsc_pkg::MODE_MAX:
                if (v > run_max)
                    run_max = v;
            rsc_pkg::MODE_MEAN:
            begin
                // sum saturates instead of wrapping
                s = 64'(run_sum) + 64'(v);
                run_sum = (s > 64'(rsc_pkg::SUM_MAX)) ? rsc_pkg::SUM_MAX : 28'(s);
            end
            rsc_pkg::MODE_ALPHA:
            begin
                vn = 64'(v) * 256;
                tn = 64'(cur_th) * 255;
                // nothing added below threshold or once coverage hit 0.98
                if (!early_stop && vn > tn)
                begin
                    a = ((vn - tn) * 64'(cur_scale)) / (255 * 65536);
                    if (a > 65536)
                        a = 65536;
                    w = ((65536 - 64'(cov)) * a) >> 16;
                    cov = cov + 17'(w);
                    acc = 64'(color_acc) + ((w * 64'(v)) >> 8);
                    color_acc = (acc > 64'(rsc_pkg::ACC_MAX)) ? rsc_pkg::ACC_MAX
                                                              : 24'(acc);
                    if (cov >= rsc_pkg::DONE_COV)
                        early_stop = 1'b1;
                end
            end
            default: ;
        endcase
        if (!last)
            return -1;
        // pixel uses the mode current at the end of the ray
        case (cur_mode)
            rsc_pkg::MODE_MIN:  r = q88_to_pixel(run_min);
            rsc_pkg::MODE_MAX:  r = q88_to_pixel(run_max);
            rsc_pkg::MODE_MEAN:
            begin
                n = 64'(cur_steps);
                if (n == 0)
                    r = 0;
                else
                begin
                    q = (2 * 64'(run_sum) + 256 * n) / (512 * n);
                    r = (q > 255) ? 255 : int'(q);
                end
            end
            rsc_pkg::MODE_ALPHA:
            begin
                r = (int'(color_acc) + 32768) >> 16;
                if (r > 255)
                    r = 255;
            end
            default:   r = 0;
        endcase
        clear_ray();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // pixel checker and consumer stall
    // ------------------------------------------------------------------------

    // every pixel taken is compared with the oldest prediction; after each one
    // the consumer draws how many cycles it holds off the next
    always @(posedge clk)
    begin : pixel_check
        logic [rsc_pkg::PIXEL_W-1:0] want;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: pixel %0d arrived with none expected", $time, pixel);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (pixel !== want)
                begin
                    $display("%0t: pixel mismatch, expected %0d, got %0d",
                             $time, want, pixel);
                    fail_count++;
                end
            end
            sink_hold = $urandom_range(max_sink_gap, 0);
        end
        else if (sink_hold > 0)
            sink_hold--;
        pixel_stall <= (sink_hold > 0);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one sample request; valid stays high afterwards so requests can go
    // back to back, wait_idle lowers it
    task automatic send_sample(input logic [rsc_pkg::SAMPLE_W-1:0] v, input bit last,
                               input bit vd);
        int gap;
        int px;
        gap = $urandom_range(max_src_gap, 0);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_value <= v;
        ray_last     <= last;
        ray_void     <= vd;
        do
            @(posedge clk);
        while (sample_stall);
        samples_sent++;
        px = predict_pixel(v, last, vd);
        if (px >= 0)
            pending_pixels.push_back(8'(px));
    endtask

    // a whole ray of given length, last mark on the final sample
    task automatic send_ray(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_sample(pick_sample(), i == len - 1, 1'b0);
    endtask

    // drain every pixel, then let a sample that yields none finish too
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [rsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rsc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // sample mix: anything, near zero, near full scale, or around the
    // alpha threshold so opacity ramps from small values
    function automatic logic [rsc_pkg::SAMPLE_W-1:0] pick_sample();
        int sel;
        int val;
        sel = $urandom_range(3, 0);
        case (sel)
            0:       val = $urandom_range(65535, 0);
            1:       val = $urandom_range(511, 0);
            2:       val = $urandom_range(65535, 61440);
            default:
            begin
                val = (int'(cur_th) * 255) / 256 + $urandom_range(256, 0) - 64;
                if (val < 0)
                    val = 0;
                if (val > 65535)
                    val = 65535;
            end
        endcase
        return 16'(val);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // registers at reset values: pass-through, rounding edges and saturation
    task automatic test_reset_passthrough();
        send_sample(16'h0000, 1'b0, 1'b0);
        send_sample(16'h007F, 1'b0, 1'b0);    // just below half
        send_sample(16'h0080, 1'b0, 1'b0);    // half rounds up
        send_sample(16'h1280, 1'b0, 1'b0);
        send_sample(16'hFF7F, 1'b0, 1'b0);
        send_sample(16'hFF80, 1'b0, 1'b0);    // rounds past 255
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'hABCD, 1'b1, 1'b1);    // void ray in pass-through
    endtask

    task automatic test_min_max();
        wait_idle();
        write_reg(rsc_pkg::REG_COMP_MODE, 23'(rsc_pkg::MODE_MIN));
        send_sample(16'h4000, 1'b0, 1'b0);
        send_sample(16'h00FF, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b1, 1'b0);
        // nothing below the 255.0 start value
        send_sample(16'hFFFF, 1'b1, 1'b0);
        wait_idle();
        write_reg(rsc_pkg::REG_COMP_MODE, 23'(rsc_pkg::MODE_MAX));
        send_sample(16'h0010, 1'b0, 1'b0);
        send_sample(16'hFE90, 1'b1, 1'b0);
    endtask

    task automatic test_mean();
        wait_idle();
        write_reg(rsc_pkg::REG_COMP_MODE, 23'(rsc_pkg::MODE_MEAN));
        write_reg(rsc_pkg::REG_STEPS_PER_RAY, 23'd3);
        send_sample(16'h0100, 1'b0, 1'b0);
        send_sample(16'h0200, 1'b0, 1'b0);
        send_sample(16'h0300, 1'b1, 1'b0);
        // zero steps gives a black pixel
        wait_idle();
        write_reg(rsc_pkg::REG_STEPS_PER_RAY, 23'd0);
        send_sample(16'h5555, 1'b1, 1'b0);
    endtask

    task automatic test_alpha();
        wait_idle();
        write_reg(rsc_pkg::REG_COMP_MODE, 23'(rsc_pkg::MODE_ALPHA));
        write_reg(rsc_pkg::REG_ALPHA_THRESHOLD, 23'd0);
        write_reg(rsc_pkg::REG_ALPHA_SCALE, 23'd65536);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h4000, 1'b1, 1'b0);
        // threshold above 0.99 is clamped, only the top sample passes
        wait_idle();
        write_reg(rsc_pkg::REG_ALPHA_THRESHOLD, 23'd65535);
        send_sample(16'hF000, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        // full gain: first sample saturates coverage, the rest is ignored
        wait_idle();
        write_reg(rsc_pkg::REG_ALPHA_THRESHOLD, 23'd0);
        write_reg(rsc_pkg::REG_ALPHA_SCALE, 23'h7FFFFF);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b1, 1'b0);
    endtask

    // modes 5..7 accumulate nothing and end rays with pixel 0
    task automatic test_unused_modes();
        int m;
        for (m = 5; m <= 7; m++)
        begin
            wait_idle();
            write_reg(rsc_pkg::REG_COMP_MODE, 23'(m));
            send_sample(16'hC0DE, 1'b1, 1'b0);
        end
    endtask

    // void in the middle of a ray clears it, then a short ray follows
    task automatic test_void_mid_ray();
        wait_idle();
        write_reg(rsc_pkg::REG_COMP_MODE, 23'(rsc_pkg::MODE_MAX));
        send_sample(16'hF000, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b1);
        send_sample(16'h0300, 1'b1, 1'b0);
    endtask

    // mode changes between samples of one ray
    task automatic test_mode_switch();
        wait_idle();
        write_reg(rsc_pkg::REG_COMP_MODE, 23'(rsc_pkg::MODE_MEAN));
        write_reg(rsc_pkg::REG_STEPS_PER_RAY, 23'd1);
        send_sample(16'h8000, 1'b0, 1'b0);
        wait_idle();
        write_reg(rsc_pkg::REG_COMP_MODE, 23'(rsc_pkg::MODE_MAX));
        send_sample(16'h2000, 1'b0, 1'b0);
        wait_idle();
        write_reg(rsc_pkg::REG_COMP_MODE, 23'(rsc_pkg::MODE_MEAN));
        send_sample(16'h0100, 1'b1, 1'b0);
    endtask

    // phases of random rays, each with a fresh register set
    task automatic test_random_rays();
        int phase;
        int sent;
        int ray_len;
        int len;
        int sel;
        int i;
        logic [rsc_pkg::CFG_DATA_W-1:0] val;
        for (phase = 0; phase < 16; phase++)
        begin
            wait_idle();
            // each real mode three times, the last phase in an unused mode
            if (phase < 15)
                write_reg(rsc_pkg::REG_COMP_MODE, 23'(phase % 5));
            else
                write_reg(rsc_pkg::REG_COMP_MODE, 23'($urandom_range(7, 5)));

            sel = $urandom_range(3, 0);
            case (sel)
                0:       val = 23'd0;
                1:       val = 23'd65535;
                2:       val = 23'($urandom_range(65535, 0));
                default: val = 23'($urandom_range(20000, 0));
            endcase
            write_reg(rsc_pkg::REG_ALPHA_THRESHOLD, val);

            sel = $urandom_range(5, 0);
            case (sel)
                0:       val = 23'd0;
                1:       val = 23'h7FFFFF;
                2:       val = 23'($urandom_range(23'h7FFFFF, 0));
                3:       val = 23'd65536;
                default: val = 23'($urandom_range(1 << 20, 1 << 16));
            endcase
            write_reg(rsc_pkg::REG_ALPHA_SCALE, val);

            ray_len = ($urandom_range(7, 0) == 0) ? 20 : $urandom_range(8, 1);
            sel = $urandom_range(5, 0);
            case (sel)
                0:       val = 23'd0;
                1:       val = 23'd8191;
                2:       val = 23'($urandom_range(8191, 0));
                default: val = 23'(ray_len);
            endcase
            write_reg(rsc_pkg::REG_STEPS_PER_RAY, val);

            // some phases run one or both sides without idling
            max_src_gap  = (phase % 4 == 1 || phase % 4 == 3) ? 0 : 5;
            max_sink_gap = (phase % 4 == 2 || phase % 4 == 3) ? 0 : 5;

            // mostly well-formed rays, some odd lengths and void requests;
            // a ray cut at phase end carries into the next register set
            sent = 0;
            while (sent < 57)
            begin
                sel = $urandom_range(19, 0);
                if (sel == 0)
                begin
                    send_sample(16'($urandom_range(65535, 0)), 1'($urandom_range(1, 0)),
                                1'b1);
                    sent++;
                end
                else
                begin
                    len = (sel == 1) ? $urandom_range(2 * ray_len, 1) : ray_len;
                    for (i = 0; i < len && sent < 57; i++)
                    begin
                        send_sample(pick_sample(), i == len - 1, 1'b0);
                        sent++;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cur_mode  = rsc_pkg::MODE_NONE;
        cur_th    = '0;
        cur_scale = 23'd65536;
        cur_steps = 13'd1;
        clear_ray();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        max_src_gap  = 5;
        max_sink_gap = 5;
        test_reset_passthrough();
        test_min_max();
        test_mean();
        test_alpha();
        test_unused_modes();
        test_void_mid_ray();
        test_mode_switch();
        send_ray(3);
        test_random_rays();

        // wait out the last pixels and any trailing work
        wait_idle();
        repeat (16) @(posedge clk);

        $display("covered %0d sample requests over all modes, %0d register writes",
                 samples_sent, reg_writes);
        $display("compared %0d pixels, %0d failures", pixels_checked, fail_count);
        if (fail_count == 0)
            $display("** ray_sample_compositor: PASSED **");
        else
            $display("** ray_sample_compositor: FAILED **");
        $finish;
    end

    // hang guard
    initial
    begin
        #20_000_000;
        $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
        $display("** ray_sample_compositor: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
sv/rsc_pkg.sv
sv/ray_sample_compositor.sv
tb/sv/ray_sample_compositor_test.sv
